@@ src/itc_pkg.sv @@
// ----------------------------------------------------------------------------
// itc_pkg: shared types and constants of the input trigger classifier.
// Holds the mode and trigger state codes, the register indexes and the
// structs that travel between the configuration, front and core logic.
// ----------------------------------------------------------------------------
package itc_pkg;

    // Field widths of the input word, result word and registers.
    localparam int MagW    = 16;
    localparam int DtW     = 24;
    localparam int DilW    = 16;
    localparam int TimeW   = 32;
    localparam int CountW  = 16;
    localparam int ModeW   = 3;
    localparam int StateW  = 2;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 32;

    // Dilation is Q8.8, so the scaled product drops eight fraction bits.
    localparam int DilFracW = 8;

    // Trigger modes.
    localparam logic [ModeW-1:0] MODE_DOWN         = 3'd0;
    localparam logic [ModeW-1:0] MODE_PRESSED      = 3'd1;
    localparam logic [ModeW-1:0] MODE_RELEASED     = 3'd2;
    localparam logic [ModeW-1:0] MODE_HOLD         = 3'd3;
    localparam logic [ModeW-1:0] MODE_HOLD_RELEASE = 3'd4;
    localparam logic [ModeW-1:0] MODE_TAP          = 3'd5;
    localparam logic [ModeW-1:0] MODE_PULSE        = 3'd6;

    // Trigger states of the result word.
    localparam logic [StateW-1:0] ST_NONE      = 2'd0;
    localparam logic [StateW-1:0] ST_ONGOING   = 2'd1;
    localparam logic [StateW-1:0] ST_TRIGGERED = 2'd2;

    // Register indexes of the configuration port.
    localparam logic [CfgIdxW-1:0] REG_MODE            = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_ACTUATION_LEVEL = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_TIME_THRESHOLD  = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_PULSE_LIMIT     = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_ONE_SHOT        = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_FIRE_ON_START   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_USE_DILATION    = 3'd6;

    // Reset values of the registers.
    localparam logic [MagW-1:0]   RST_ACTUATION_LEVEL = 16'd32768;
    localparam logic [TimeW-1:0]  RST_TIME_THRESHOLD  = 32'd65536;

    // Configuration register set.
    typedef struct packed {
        logic [ModeW-1:0]  mode;
        logic [MagW-1:0]   actuation_level;
        logic [TimeW-1:0]  time_threshold;
        logic [CountW-1:0] pulse_limit;
        logic              one_shot;
        logic              fire_on_start;
        logic              use_dilation;
    } t_cfg;

    // One prepared tick as handed from the front stage to the core.
    typedef struct packed {
        logic             act;
        logic [TimeW-1:0] step;
    } t_tick;

endpackage

@@ src/itc_front.sv @@
// ----------------------------------------------------------------------------
// itc_front: input stage of the trigger classifier.
// Compares the magnitude against the actuation level, scales the delta time
// by the dilation when enabled and registers the prepared tick.
// ----------------------------------------------------------------------------
module itc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  itc_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [itc_pkg::MagW-1:0]       i_magnitude,
    input  logic [itc_pkg::DtW-1:0]        i_delta_time,
    input  logic [itc_pkg::DilW-1:0]       i_dilation,
    output logic                           o_tick_valid,
    output itc_pkg::t_tick                 o_tick,
    input  logic                           i_tick_take
);
    import itc_pkg::*;

    localparam int ProdW = DtW + DilW;

    logic              r_valid;
    logic              n_valid;
    t_tick             r_tick;
    t_tick             n_tick;
    logic [ProdW-1:0]  w_prod;
    logic              w_accept;

    // The stage takes a word when empty or when its word moves on.
    assign o_stall  = r_valid && !i_tick_take;
    assign w_accept = i_valid && !o_stall;

    // Tick time in Q16.16, scaled by the Q8.8 dilation when enabled.
    assign w_prod = ProdW'(i_delta_time) * ProdW'(i_dilation);

    always_comb begin
        n_tick.act  = i_magnitude >= i_cfg.actuation_level;
        n_tick.step = i_cfg.use_dilation ? w_prod[ProdW-1:DilFracW]
                                         : TimeW'(i_delta_time);
    end

    // Stage occupancy.
    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (i_tick_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tick <= n_tick;
        end
    end

    assign o_tick_valid = r_valid;
    assign o_tick       = r_tick;

endmodule

@@ src/itc_core.sv @@
// ----------------------------------------------------------------------------
// itc_core: classification stage of the trigger classifier.
// Holds the held time, previous actuation, hold-fired flag and pulse count,
// classifies each tick under the configured mode and registers the result.
// ----------------------------------------------------------------------------
module itc_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  itc_pkg::t_cfg                   i_cfg,
    input  logic                            i_tick_valid,
    input  itc_pkg::t_tick                  i_tick,
    output logic                            o_tick_take,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [itc_pkg::StateW-1:0]      o_trigger_state
);
    import itc_pkg::*;

    localparam int MultW  = CountW + 1;
    localparam int PulseW = TimeW + MultW;

    logic                r_out_valid;
    logic                n_out_valid;
    logic [StateW-1:0]   r_state;
    logic [StateW-1:0]   n_state;
    logic [TimeW-1:0]    r_held;
    logic [TimeW-1:0]    n_held;
    logic                r_prev_act;
    logic                r_hold_fired;
    logic                n_hold_fired;
    logic [CountW-1:0]   r_count;
    logic [CountW-1:0]   n_count;
    logic                w_take;
    logic [TimeW:0]      w_sum;
    logic [TimeW-1:0]    w_tentative;
    logic                w_timed;
    logic [StateW-1:0]   w_base;
    logic                w_limit_ok;
    logic [MultW-1:0]    w_mult;
    logic [PulseW-1:0]   w_pulse_time;
    logic                w_pulse_fire;

    // A tick moves in when the result register is free or being drained.
    assign w_take      = i_tick_valid && (!r_out_valid || !i_stall);
    assign o_tick_take = w_take;

    // Saturating held time plus this tick's step.
    assign w_sum       = {1'b0, r_held} + {1'b0, i_tick.step};
    assign w_tentative = w_sum[TimeW] ? {TimeW{1'b1}} : w_sum[TimeW-1:0];

    assign w_timed = (i_cfg.mode == MODE_HOLD) || (i_cfg.mode == MODE_HOLD_RELEASE) ||
                     (i_cfg.mode == MODE_TAP) || (i_cfg.mode == MODE_PULSE);
    assign w_base  = i_tick.act ? ST_ONGOING : ST_NONE;

    // Updated held time: timed modes accumulate while actuated.
    always_comb begin
        n_held = r_held;
        if (w_timed) begin
            n_held = i_tick.act ? w_tentative : '0;
        end
    end

    // Pulse schedule: the next pulse is due once held time passes
    // the interval times the pulses so far (plus one without a start pulse).
    assign w_limit_ok   = (i_cfg.pulse_limit == '0) || (r_count < i_cfg.pulse_limit);
    assign w_mult       = MultW'(r_count) + MultW'(!i_cfg.fire_on_start);
    assign w_pulse_time = PulseW'(i_cfg.time_threshold) * PulseW'(w_mult);
    assign w_pulse_fire = PulseW'(n_held) > w_pulse_time;

    // Classification per mode.
    always_comb begin
        n_state      = ST_NONE;
        n_hold_fired = r_hold_fired;
        n_count      = r_count;
        case (i_cfg.mode)
            MODE_DOWN: begin
                n_state = i_tick.act ? ST_TRIGGERED : ST_NONE;
            end
            MODE_PRESSED: begin
                n_state = (i_tick.act && !r_prev_act) ? ST_TRIGGERED : ST_NONE;
            end
            MODE_RELEASED: begin
                n_state = i_tick.act ? ST_ONGOING
                                     : (r_prev_act ? ST_TRIGGERED : ST_NONE);
            end
            MODE_HOLD: begin
                n_hold_fired = n_held >= i_cfg.time_threshold;
                if (n_hold_fired) begin
                    n_state = (!r_hold_fired || !i_cfg.one_shot) ? ST_TRIGGERED
                                                                  : ST_NONE;
                end else begin
                    n_state = w_base;
                end
            end
            MODE_HOLD_RELEASE: begin
                n_state = w_base;
                if ((w_tentative >= i_cfg.time_threshold) && !i_tick.act) begin
                    n_state = ST_TRIGGERED;
                end
            end
            MODE_TAP: begin
                n_state = w_base;
                if (r_prev_act && !i_tick.act && (r_held < i_cfg.time_threshold)) begin
                    n_state = ST_TRIGGERED;
                end else if (n_held >= i_cfg.time_threshold) begin
                    n_state = ST_NONE;
                end
            end
            MODE_PULSE: begin
                n_state = w_base;
                if (i_tick.act) begin
                    if (w_limit_ok) begin
                        if (w_pulse_fire) begin
                            if (r_count != {CountW{1'b1}}) begin
                                n_count = r_count + 1'b1;
                            end
                            n_state = ST_TRIGGERED;
                        end
                    end else begin
                        n_state = ST_NONE;
                    end
                end else begin
                    n_count = '0;
                end
            end
            default: begin
                n_state = ST_NONE;
            end
        endcase
    end

    // Result word occupancy.
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_take) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Classifier state and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_held       <= '0;
            r_prev_act   <= 1'b0;
            r_hold_fired <= 1'b0;
            r_count      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            if (w_take) begin
                r_held       <= n_held;
                r_prev_act   <= i_tick.act;
                r_hold_fired <= n_hold_fired;
                r_count      <= n_count;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_state <= n_state;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_trigger_state = r_state;

endmodule

@@ src/input_trigger_classifier.sv @@
// ----------------------------------------------------------------------------
// Pipeline: input stage register, then result register. One word per
// cycle while i_stall is low; the held-time update and the pulse
// schedule multiply close in the single classification stage.
// Reset: synchronous, active low; clears the registers to their defaults,
// the classifier state and both stage valids.
// ----------------------------------------------------------------------------
// input_trigger_classifier: button trigger classifier top level.
// Holds the configuration registers and joins the input stage to the
// classification stage.
// ----------------------------------------------------------------------------
module input_trigger_classifier (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [itc_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [itc_pkg::CfgDataW-1:0]    i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [itc_pkg::MagW-1:0]        i_magnitude,
    input  logic [itc_pkg::DtW-1:0]         i_delta_time,
    input  logic [itc_pkg::DilW-1:0]        i_dilation,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [itc_pkg::StateW-1:0]      o_trigger_state
);
    import itc_pkg::*;

    t_cfg   r_cfg;
    t_cfg   n_cfg;
    logic   w_tick_valid;
    t_tick  w_tick;
    logic   w_tick_take;

    assign o_cfg_ready = 1'b1;

    // Register writes; an index past the list is ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MODE:            n_cfg.mode            = i_cfg_data[ModeW-1:0];
                REG_ACTUATION_LEVEL: n_cfg.actuation_level = i_cfg_data[MagW-1:0];
                REG_TIME_THRESHOLD:  n_cfg.time_threshold  = i_cfg_data[TimeW-1:0];
                REG_PULSE_LIMIT:     n_cfg.pulse_limit     = i_cfg_data[CountW-1:0];
                REG_ONE_SHOT:        n_cfg.one_shot        = i_cfg_data[0];
                REG_FIRE_ON_START:   n_cfg.fire_on_start   = i_cfg_data[0];
                REG_USE_DILATION:    n_cfg.use_dilation    = i_cfg_data[0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode            <= MODE_DOWN;
            r_cfg.actuation_level <= RST_ACTUATION_LEVEL;
            r_cfg.time_threshold  <= RST_TIME_THRESHOLD;
            r_cfg.pulse_limit     <= '0;
            r_cfg.one_shot        <= 1'b0;
            r_cfg.fire_on_start   <= 1'b1;
            r_cfg.use_dilation    <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Input stage: actuation compare and tick time scaling.
    itc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_magnitude  (i_magnitude),
        .i_delta_time (i_delta_time),
        .i_dilation   (i_dilation),
        .o_tick_valid (w_tick_valid),
        .o_tick       (w_tick),
        .i_tick_take  (w_tick_take)
    );

    // Classification stage with the result register.
    itc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_tick_valid    (w_tick_valid),
        .i_tick          (w_tick),
        .o_tick_take     (w_tick_take),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_trigger_state (o_trigger_state)
    );

endmodule
